>>> rtl/wps_pkg.sv
package wps_pkg;

  // Age counter width and its saturation value
  localparam int unsigned AGE_BITS = 32;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Fixed durations
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned PUBLISH_MS = 500;

  // Widths of the millisecond thresholds held in the config block
  localparam int unsigned AWAKE_MS_BITS = 26;  // 65535 s in ms
  localparam int unsigned LINK_MS_BITS  = 18;  // 255 s in ms
  localparam int unsigned WAIT_MS_BITS  = 16;

  // Config port widths
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEEP_SLEEP_EN   = 3'd0,
    CFG_MAX_AWAKE_SEC   = 3'd1,
    CFG_WIFI_TIMEOUT    = 3'd2,
    CFG_MQTT_TIMEOUT    = 3'd3,
    CFG_RETAINED_WAIT   = 3'd4
  } cfg_idx_e;

  // Wake phases
  typedef enum logic [2:0] {
    PH_WIFI     = 3'd0,
    PH_MQTT     = 3'd1,
    PH_RETAINED = 3'd2,
    PH_EXECUTE  = 3'd3,
    PH_PUBLISH  = 3'd4,
    PH_SLEEP    = 3'd5,
    PH_MAINT    = 3'd6
  } phase_e;

  // Item kinds
  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  // Settings, already scaled to milliseconds
  typedef struct packed {
    logic                     enabled;
    logic [AWAKE_MS_BITS-1:0] max_awake_ms;
    logic [LINK_MS_BITS-1:0]  wifi_to_ms;
    logic [LINK_MS_BITS-1:0]  mqtt_to_ms;
    logic [WAIT_MS_BITS-1:0]  retained_ms;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic kind;
    logic force_maintenance;
    logic wifi_up;
    logic broker_up;
    logic work_pending;
  } item_t;

endpackage

>>> rtl/wps_ifs.sv
// Input channel: one tick or restart request
interface wps_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic force_maintenance;
  logic wifi_up;
  logic broker_up;
  logic work_pending;

  modport source (
    output valid, kind, force_maintenance, wifi_up, broker_up, work_pending,
    input  ready
  );
  modport sink (
    input  valid, kind, force_maintenance, wifi_up, broker_up, work_pending,
    output ready
  );
endinterface

// Output channel: phase after each request
interface wps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic       sleep_now;

  modport source (
    output valid, phase, sleep_now,
    input  ready
  );
  modport sink (
    input  valid, phase, sleep_now,
    output ready
  );
endinterface

>>> rtl/wps_cfg_regs.sv
module wps_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wps_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [wps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  output wps_pkg::cfg_t                         cfg_o
);
  import wps_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Seconds are scaled to ms at write time
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEEP_SLEEP_EN: cfg_d.enabled = cfg_wdata_i[0];
        CFG_MAX_AWAKE_SEC: cfg_d.max_awake_ms =
            AWAKE_MS_BITS'(cfg_wdata_i) * AWAKE_MS_BITS'(MS_PER_SEC);
        CFG_WIFI_TIMEOUT: cfg_d.wifi_to_ms =
            LINK_MS_BITS'(cfg_wdata_i[7:0]) * LINK_MS_BITS'(MS_PER_SEC);
        CFG_MQTT_TIMEOUT: cfg_d.mqtt_to_ms =
            LINK_MS_BITS'(cfg_wdata_i[7:0]) * LINK_MS_BITS'(MS_PER_SEC);
        CFG_RETAINED_WAIT: cfg_d.retained_ms = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= 1'b1;
      cfg_q.max_awake_ms <= AWAKE_MS_BITS'(60 * MS_PER_SEC);
      cfg_q.wifi_to_ms   <= LINK_MS_BITS'(15 * MS_PER_SEC);
      cfg_q.mqtt_to_ms   <= LINK_MS_BITS'(10 * MS_PER_SEC);
      cfg_q.retained_ms  <= WAIT_MS_BITS'(500);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wps_seq.sv
module wps_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  wps_pkg::item_t item_i,
  input  wps_pkg::cfg_t  cfg_i,
  output wps_pkg::phase_e phase_o
);
  import wps_pkg::*;

  phase_e              phase_q, phase_d;
  logic [AGE_BITS-1:0] boot_age_q, boot_age_d;
  logic [AGE_BITS-1:0] phase_age_q, phase_age_d;
  logic [AGE_BITS-1:0] boot_inc, phase_inc;
  logic                awake_over;

  // Saturating increments
  assign boot_inc  = (boot_age_q == AGE_MAX) ? AGE_MAX : boot_age_q + 1'b1;
  assign phase_inc = (phase_age_q == AGE_MAX) ? AGE_MAX : phase_age_q + 1'b1;
  assign awake_over = boot_inc >= AGE_BITS'(cfg_i.max_awake_ms);

  // Phase step for one request
  always_comb begin
    phase_d     = phase_q;
    boot_age_d  = boot_inc;
    phase_age_d = phase_inc;
    if (item_i.kind == KIND_RESTART) begin
      boot_age_d  = '0;
      phase_age_d = '0;
      phase_d     = item_i.force_maintenance ? PH_MAINT : PH_WIFI;
    end else if (cfg_i.enabled) begin
      if (awake_over) begin
        phase_d = PH_SLEEP;
      end else begin
        case (phase_q)
          PH_WIFI: begin
            if (item_i.wifi_up) phase_d = PH_MQTT;
            else if (phase_inc >= AGE_BITS'(cfg_i.wifi_to_ms)) phase_d = PH_SLEEP;
          end
          PH_MQTT: begin
            if (item_i.broker_up) phase_d = PH_RETAINED;
            else if (phase_inc >= AGE_BITS'(cfg_i.mqtt_to_ms)) phase_d = PH_SLEEP;
          end
          PH_RETAINED: begin
            if (phase_inc >= AGE_BITS'(cfg_i.retained_ms)) phase_d = PH_EXECUTE;
          end
          PH_EXECUTE: begin
            if (!item_i.work_pending) phase_d = PH_PUBLISH;
          end
          PH_PUBLISH: begin
            if (phase_inc >= AGE_BITS'(PUBLISH_MS)) phase_d = PH_SLEEP;
          end
          default: ;
        endcase
      end
      // Any phase entry, including sleep re-entry, clears the phase age
      if (awake_over || phase_d != phase_q) phase_age_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WIFI;
      boot_age_q  <= '0;
      phase_age_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      boot_age_q  <= boot_age_d;
      phase_age_q <= phase_age_d;
    end
  end

  assign phase_o = phase_d;

endmodule

>>> rtl/wake_phase_sequencer_core.sv
// Wake phase sequencer. Takes one tick or restart request per clock cycle
// while in_ch.ready is high and returns one result per request: the phase
// after that request and a sleep flag. The sequencer state updates as a
// request moves from the input register to the result register, so requests
// follow back to back at one per cycle while the output is not stalled.
// in_ch.ready drops only while both registers hold requests and the result
// is not being taken. Config writes are taken at any time but should be made
// while no request is in flight; second values are scaled to ms on write.
module wake_phase_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wps_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [wps_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  wps_in_if.sink                            in_ch,
  wps_out_if.source                         out_ch
);
  import wps_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  item_t  s1_item_q;
  logic   s1_valid_q;
  logic   out_valid_q;
  phase_e out_phase_q;
  phase_e res_phase;
  logic   out_free, s1_move, in_take;

  // Handshake between stages
  assign out_free = !out_valid_q || out_ch.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_q || out_free;

  assign in_item = '{
    kind:              in_ch.kind,
    force_maintenance: in_ch.force_maintenance,
    wifi_up:           in_ch.wifi_up,
    broker_up:         in_ch.broker_up,
    work_pending:      in_ch.work_pending
  };

  wps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_move),
    .item_i  (s1_item_q),
    .cfg_i   (cfg),
    .phase_o (res_phase)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_item_q <= in_item;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) out_phase_q <= res_phase;
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.phase     = out_phase_q;
  assign out_ch.sleep_now = (out_phase_q == PH_SLEEP);

endmodule
